[hw/rtl/bcf_pkg.sv]
// bcf_pkg: types, register indexes and constants shared by the compensation filter
// used by bcf_front, bcf_queue, bcf_back, the top level and the checker
`default_nettype none

package bcf_pkg;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
	} bcf_in_t;

	typedef struct packed {
		logic signed [14:0] temperature_centi_c;
		logic        [24:0] pressure_q24_8;
		logic               pressure_invalid;
	} bcf_out_t;

	// register file contents handed to front and back
	typedef struct packed {
		logic [47:0] temp_cal;
		logic [47:0] press_a;
		logic [47:0] press_b;
		logic [47:0] press_c;
		logic        filt_en;
		logic [2:0]  filt_log2;
	} bcf_cfg_t;

	// item after temperature compensation, waiting for the pressure sequencer
	typedef struct packed {
		logic        [19:0] raw_pressure;
		logic signed [19:0] t_fine;
		logic signed [14:0] temperature;
	} bcf_work_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ, ST_V2A, ST_V2B, ST_V2C, ST_V1A, ST_V1B,
		ST_PA, ST_PB, ST_PC, ST_NCHK, ST_N1, ST_N2, ST_N3,
		ST_DCHK, ST_DIV, ST_SGN, ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_OUT
	} bcf_state_t;

	localparam logic [2:0] CFG_TEMP_CAL  = 3'd0;
	localparam logic [2:0] CFG_PRESS_A   = 3'd1;
	localparam logic [2:0] CFG_PRESS_B   = 3'd2;
	localparam logic [2:0] CFG_PRESS_C   = 3'd3;
	localparam logic [2:0] CFG_FILT_EN   = 3'd4;
	localparam logic [2:0] CFG_FILT_LOG2 = 3'd5;

	localparam logic signed [23:0] TFINE_MIN = -24'sd204800;
	localparam logic signed [23:0] TFINE_MAX = 24'sd435200;
	localparam logic signed [19:0] TFINE_REF = 20'sd128000;
	localparam logic [24:0]        PQ_MAX    = 25'h1FF_FFFF;
	localparam logic [36:0]        Q_LIMIT   = 37'h10_0000_0000;
	localparam logic [24:0]        DIV_SCALE = 25'd3125;
	localparam logic [5:0]         DIV_STEPS = 6'd36;
	localparam logic [20:0]        P_FULL    = 21'd1048576;

endpackage

`default_nettype wire

[hw/rtl/bcf_front.sv]
// bcf_front: four-stage temperature compensation pipeline, produces t_fine and temperature
// depends on bcf_pkg
`default_nettype none

module bcf_front import bcf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire bcf_cfg_t  cfg,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire bcf_in_t   in_item,
	output logic           push_valid,
	input  wire logic      push_ready,
	output bcf_work_t      push_item
);

	logic               adv;
	logic               v_s1, v_s2, v_s3, v_s4;
	logic [19:0]        rp_s1, rp_s2, rp_s3;
	logic signed [17:0] d1_s1;
	logic signed [16:0] x_s1;
	logic signed [33:0] v1m_s2, xx_s2;
	logic signed [22:0] v1_s3;
	logic signed [37:0] w_s3;
	bcf_work_t          work_s4;
	logic [15:0]        t1;
	logic signed [15:0] t2, t3;
	logic signed [23:0] tf_raw;
	logic signed [19:0] tf_sat;
	logic signed [22:0] tf5;

	assign t1 = cfg.temp_cal[15:0];
	assign t2 = $signed(cfg.temp_cal[31:16]);
	assign t3 = $signed(cfg.temp_cal[47:32]);

	// whole pipe moves unless the last stage is blocked by a full queue
	assign adv        = !(v_s4 && !push_ready);
	assign in_stall   = !adv;
	assign push_valid = v_s4;
	assign push_item  = work_s4;

	always_comb begin
		tf_raw = 24'(v1_s3) + 24'(w_s3[37:14]);
		if (tf_raw < TFINE_MIN) begin
			tf_sat = 20'(TFINE_MIN);
		end else if (tf_raw > TFINE_MAX) begin
			tf_sat = 20'(TFINE_MAX);
		end else begin
			tf_sat = tf_raw[19:0];
		end
		tf5 = (23'(tf_sat) <<< 2) + 23'(tf_sat) + 23'sd128;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rp_s1  <= in_item.raw_pressure;
			d1_s1  <= $signed({1'b0, in_item.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
			x_s1   <= $signed({1'b0, in_item.raw_temperature[19:4]}) - $signed({1'b0, t1});
			rp_s2  <= rp_s1;
			v1m_s2 <= d1_s1 * t2;
			xx_s2  <= x_s1 * x_s1;
			rp_s3  <= rp_s2;
			v1_s3  <= v1m_s2[33:11];
			w_s3   <= $signed(xx_s2[33:12]) * t3;
			work_s4.raw_pressure <= rp_s3;
			work_s4.t_fine       <= tf_sat;
			work_s4.temperature  <= tf5[22:8];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/bcf_queue.sv]
// bcf_queue: small flop queue between temperature front and pressure back
// depends on bcf_pkg
`default_nettype none

module bcf_queue import bcf_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push_valid,
	output logic           push_ready,
	input  wire bcf_work_t push_item,
	output logic           pop_valid,
	input  wire logic      pop_ready,
	output bcf_work_t      pop_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bcf_work_t        mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/bcf_back.sv]
// bcf_back: pressure sequencer with one shared multiplier, bit-serial divider,
// running filter and output register; depends on bcf_pkg
`default_nettype none

module bcf_back import bcf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire bcf_cfg_t  cfg,
	input  wire logic      pop_valid,
	output logic           pop_ready,
	input  wire bcf_work_t pop_item,
	output logic           out_valid,
	input  wire logic      out_stall,
	output bcf_out_t       out_item
);

	bcf_state_t         state_q, state_nx;
	logic signed [39:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [64:0] prod_q;

	logic [19:0]        adcp_q;
	logic signed [14:0] temp_q;
	logic signed [19:0] vf_q;
	logic signed [37:0] sq_q;
	logic signed [55:0] acc_q, v2_q;
	logic [63:0]        m_q;
	logic [30:0]        vm_q, rem_q;
	logic [53:0]        dm_q;
	logic               dneg_q;
	logic [65:0]        n_q;
	logic [36:0]        nlo_q, quo_q;
	logic [5:0]         cnt_q;
	logic signed [37:0] p_q;
	logic signed [39:0] v1c_q;
	logic [24:0]        pc_q, filt_q;
	logic               inv_q;
	logic               out_valid_q;
	bcf_out_t           out_q;

	logic [15:0]        p1;
	logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
	logic [20:0]        pmag;
	logic signed [56:0] dval, dabs;
	logic [30:0]        vm_nx;
	logic [31:0]        trial;
	logic               ge;
	logic signed [41:0] psum, pfin;
	logic [24:0]        pclamp;
	logic [29:0]        fsum;
	logic [24:0]        pq;
	logic               filt_on, out_free;

	assign p1 = cfg.press_a[15:0];
	assign p2 = $signed(cfg.press_a[31:16]);
	assign p3 = $signed(cfg.press_a[47:32]);
	assign p4 = $signed(cfg.press_b[15:0]);
	assign p5 = $signed(cfg.press_b[31:16]);
	assign p6 = $signed(cfg.press_b[47:32]);
	assign p7 = $signed(cfg.press_c[15:0]);
	assign p8 = $signed(cfg.press_c[31:16]);
	assign p9 = $signed(cfg.press_c[47:32]);

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// pressure numerator and divisor
	always_comb begin
		pmag  = P_FULL - {1'b0, adcp_q};
		dval  = $signed({5'b0, pmag, 31'b0}) - 57'(v2_q);
		dabs  = dval[56] ? -dval : dval;
		vm_nx = m_q[63:33];
	end

	// one restoring division step
	always_comb begin
		trial = {rem_q, nlo_q[36]};
		ge    = trial >= {1'b0, vm_q};
	end

	// final sum, clamp and running filter
	always_comb begin
		psum = 42'(p_q) + 42'(v1c_q) + 42'($signed(prod_q[58:19]));
		pfin = 42'(psum >>> 8) + (42'(p7) <<< 4);
		if (pfin < 42'sd0) begin
			pclamp = '0;
		end else if (pfin > $signed({17'b0, PQ_MAX})) begin
			pclamp = PQ_MAX;
		end else begin
			pclamp = pfin[24:0];
		end
		filt_on = cfg.filt_en && cfg.filt_log2 != 3'd0 && cfg.filt_log2 <= 3'd4;
		fsum    = ({5'b0, filt_q} << cfg.filt_log2) - {5'b0, filt_q} + {5'b0, pc_q};
		if (inv_q) begin
			pq = '0;
		end else if (filt_on) begin
			pq = 25'(fsum >> cfg.filt_log2);
		end else begin
			pq = pc_q;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (pop_valid) state_nx = ST_SQ;
			ST_SQ:   state_nx = ST_V2A;
			ST_V2A:  state_nx = ST_V2B;
			ST_V2B:  state_nx = ST_V2C;
			ST_V2C:  state_nx = ST_V1A;
			ST_V1A:  state_nx = ST_V1B;
			ST_V1B:  state_nx = ST_PA;
			ST_PA:   state_nx = ST_PB;
			ST_PB:   state_nx = ST_PC;
			ST_PC:   state_nx = ST_NCHK;
			ST_NCHK: state_nx = (vm_nx == '0) ? ST_OUT : ST_N1;
			ST_N1:   state_nx = ST_N2;
			ST_N2:   state_nx = ST_N3;
			ST_N3:   state_nx = ST_DCHK;
			ST_DCHK: state_nx = ({2'b0, n_q[65:37]} >= vm_q) ? ST_SGN : ST_DIV;
			ST_DIV:  if (cnt_q == '0) state_nx = ST_SGN;
			ST_SGN:  state_nx = ST_Q1;
			ST_Q1:   state_nx = ST_Q2;
			ST_Q2:   state_nx = ST_Q3;
			ST_Q3:   state_nx = ST_Q4;
			ST_Q4:   state_nx = ST_OUT;
			ST_OUT:  if (out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// multiplier operand selection and queue pop
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		pop_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: pop_ready = 1'b1;
			ST_SQ: begin
				mul_a = 40'(vf_q);
				mul_b = 25'(vf_q);
			end
			ST_V2A: begin
				mul_a = $signed(prod_q[39:0]);
				mul_b = 25'(p6);
			end
			ST_V2B: begin
				mul_a = 40'(vf_q);
				mul_b = 25'(p5);
			end
			ST_V2C: begin
				mul_a = 40'(sq_q);
				mul_b = 25'(p3);
			end
			ST_V1A: begin
				mul_a = 40'(vf_q);
				mul_b = 25'(p2);
			end
			ST_PA: begin
				mul_a = $signed({16'b0, acc_q[23:0]});
				mul_b = $signed({9'b0, p1});
			end
			ST_PB: begin
				mul_a = $signed({16'b0, acc_q[47:24]});
				mul_b = $signed({9'b0, p1});
			end
			ST_N1: begin
				mul_a = $signed({13'b0, dm_q[26:0]});
				mul_b = $signed(DIV_SCALE);
			end
			ST_N2: begin
				mul_a = $signed({13'b0, dm_q[53:27]});
				mul_b = $signed(DIV_SCALE);
			end
			ST_Q1: begin
				mul_a = 40'(p9);
				mul_b = p_q[37:13];
			end
			ST_Q2: begin
				mul_a = $signed(prod_q[39:0]);
				mul_b = p_q[37:13];
			end
			ST_Q3: begin
				mul_a = 40'(p_q);
				mul_b = 25'(p8);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			filt_q      <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				if (!inv_q) begin
					filt_q <= pq;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				adcp_q <= pop_item.raw_pressure;
				temp_q <= pop_item.temperature;
				vf_q   <= pop_item.t_fine - TFINE_REF;
			end
			ST_V2A: sq_q  <= prod_q[37:0];
			ST_V2B: acc_q <= $signed(prod_q[55:0]) + (56'(p4) <<< 35);
			ST_V2C: acc_q <= acc_q + ($signed(prod_q[55:0]) <<< 17);
			ST_V1A: begin
				v2_q  <= acc_q;
				acc_q <= $signed(prod_q[63:8]) + 56'sd140737488355328;
			end
			ST_V1B: acc_q <= acc_q + ($signed(prod_q[55:0]) <<< 12);
			ST_PB:  m_q   <= prod_q[63:0];
			ST_PC:  m_q   <= m_q + {prod_q[39:0], 24'b0};
			ST_NCHK: begin
				inv_q  <= vm_nx == '0;
				vm_q   <= vm_nx;
				dm_q   <= dabs[53:0];
				dneg_q <= dval[56];
			end
			ST_N2: n_q <= {26'b0, prod_q[39:0]};
			ST_N3: n_q <= n_q + {prod_q[38:0], 27'b0};
			ST_DCHK: begin
				// quotient of 2^37 or more saturates at once
				quo_q <= Q_LIMIT;
				rem_q <= {2'b0, n_q[65:37]};
				nlo_q <= n_q[36:0];
				cnt_q <= DIV_STEPS;
			end
			ST_DIV: begin
				rem_q <= ge ? 31'(trial - {1'b0, vm_q}) : trial[30:0];
				quo_q <= {quo_q[35:0], ge};
				nlo_q <= {nlo_q[35:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_SGN: begin
				if (quo_q[36]) begin
					p_q <= dneg_q ? -$signed({1'b0, Q_LIMIT}) : $signed({1'b0, Q_LIMIT});
				end else begin
					p_q <= dneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
				end
			end
			ST_Q3: v1c_q <= prod_q[64:25];
			ST_Q4: pc_q  <= pclamp;
			ST_OUT: begin
				if (out_free) begin
					out_q.temperature_centi_c <= temp_q;
					out_q.pressure_q24_8      <= pq;
					out_q.pressure_invalid    <= inv_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/barometric_compensation_filter_unit.sv]
// path from input item to result: 4 front stages, queue, back sequencer
// the back sequencer takes one item at a time and pops the next only from idle: 20 steps
// around the shared multiplier plus 37 steps of the bit-serial divider; the divider steps are
// skipped when the quotient saturates, and the divisor check goes straight to output when the divisor is zero
// the front keeps accepting items into the queue while the back works, as long as the queue has room
// reset: arst_n clears control state, filter state and registers (filter_log2 resets to 1)
`default_nettype none

module barometric_compensation_filter_unit import bcf_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire bcf_in_t     in_item,
	// result items
	output logic             out_valid,
	input  wire logic        out_stall,
	output bcf_out_t         out_item,
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data
);

	bcf_cfg_t  cfg_q;
	logic      push_valid, push_ready;
	bcf_work_t push_item;
	logic      pop_valid, pop_ready;
	bcf_work_t pop_item;

	// writes are always taken; the user must write only while the block is idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	// register file, unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_cal  <= '0;
			cfg_q.press_a   <= '0;
			cfg_q.press_b   <= '0;
			cfg_q.press_c   <= '0;
			cfg_q.filt_en   <= 1'b0;
			cfg_q.filt_log2 <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TEMP_CAL:  cfg_q.temp_cal  <= cfg_data;
				CFG_PRESS_A:   cfg_q.press_a   <= cfg_data;
				CFG_PRESS_B:   cfg_q.press_b   <= cfg_data;
				CFG_PRESS_C:   cfg_q.press_c   <= cfg_data;
				CFG_FILT_EN:   cfg_q.filt_en   <= cfg_data[0];
				CFG_FILT_LOG2: cfg_q.filt_log2 <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// front: temperature compensation, t_fine goes along with the raw pressure
	bcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// decouples the fast front from the slow pressure sequencer
	bcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// back: pressure polynomial, division, saturation, running filter, result register
	bcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

[hw/rtl/bcf_checker.sv]
// bcf_checker: port-level assertions for the compensation filter, bound to the top level
// depends on bcf_pkg
`default_nettype none

module bcf_checker import bcf_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     out_valid,
	input wire logic     out_stall,
	input wire bcf_out_t out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// a zero divisor always forces zero pressure
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.pressure_invalid |-> out_item.pressure_q24_8 == '0)
		else $error("invalid pressure not zero");

	// temperature stays inside the sensor range
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.temperature_centi_c >= -15'sd4000 &&
			out_item.temperature_centi_c <= 15'sd8500)
		else $error("temperature out of range");

endmodule

bind barometric_compensation_filter_unit bcf_checker u_bcf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

`default_nettype wire

[dv/barometric_compensation_filter_unit_tb.sv]
// testbench for barometric_compensation_filter_unit: raw readings in, compensated results out
// depends on bcf_pkg and the unit; predicts each result with its own integer compensation model
`default_nettype none

module barometric_compensation_filter_unit_tb;
	import bcf_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint TF_LO = -204800;
	localparam longint TF_HI = 435200;
	localparam longint PRESS_CAP = 33554431;
	localparam longint QUOT_CAP = 64'd68719476736;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	bcf_in_t     in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	bcf_out_t    out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;

	// predictor copy of the registers and the filter state
	logic [47:0] m_temp_cal, m_press_a, m_press_b, m_press_c;
	logic        m_filt_en;
	logic [2:0]  m_filt_log2;
	logic [24:0] m_filtered;

	bcf_in_t  pending_readings[$];
	bcf_out_t expected_results[$];

	int  mismatches = 0;
	int  idle_cycles = 0;
	int  quiet_cycles = 0;
	bit  timed_out = 0;
	bit  drain_hold = 0;  // sender waits for the pipe to empty
	int  rx_hold_cycles = 0;  // long receiver hold-off, counted by the monitor
	bit  stimulus_done = 0;

	barometric_compensation_filter_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint sra(longint x, int n);
		return x >>> n;
	endfunction

	function automatic longint cal_s(logic [47:0] r, int pos);
		return longint'($signed(r[16*pos +: 16]));
	endfunction

	// compensation of one reading, updates the filter state
	function automatic bcf_out_t compensate(bcf_in_t rd);
		bcf_out_t res;
		longint adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint x, v1, v2, tf, temp, p, a, d, sv;
		longint unsigned m, dm, vm, qa, qr, q, pq;
		bit bad;
		adc_p = rd.raw_pressure;
		adc_t = rd.raw_temperature;
		t1 = m_temp_cal[15:0];
		t2 = cal_s(m_temp_cal, 1);
		t3 = cal_s(m_temp_cal, 2);
		p1 = m_press_a[15:0];
		p2 = cal_s(m_press_a, 1);
		p3 = cal_s(m_press_a, 2);
		p4 = cal_s(m_press_b, 0);
		p5 = cal_s(m_press_b, 1);
		p6 = cal_s(m_press_b, 2);
		p7 = cal_s(m_press_c, 0);
		p8 = cal_s(m_press_c, 1);
		p9 = cal_s(m_press_c, 2);
		bad = 0;
		// temperature with clamped fine term
		v1 = sra(((adc_t >>> 3) - t1 * 2) * t2, 11);
		x = (adc_t >>> 4) - t1;
		v2 = sra(sra(x * x, 12) * t3, 14);
		tf = v1 + v2;
		if (tf < TF_LO) tf = TF_LO;
		if (tf > TF_HI) tf = TF_HI;
		temp = sra(tf * 5 + 128, 8);
		if (temp < -4000) temp = -4000;
		if (temp > 8500) temp = 8500;
		// pressure divisor
		v1 = tf - 128000;
		v2 = v1 * v1 * p6;
		v2 += v1 * p5 * 131072;
		v2 += p4 * 64'sd34359738368;
		v1 = sra(v1 * v1 * p3, 8) + v1 * p2 * 4096;
		a = 64'sd140737488355328 + v1;
		m = longint'(a >= 0 ? a : -a) * longint'(p1);
		if (a >= 0) v1 = longint'(m >> 33);
		else v1 = -longint'((m >> 33) + ((m & 64'h1_FFFF_FFFF) != 0));
		if (v1 == 0) begin
			bad = 1;
			pq = 0;
		end else begin
			p = 1048576 - adc_p;
			d = p * 64'sd2147483648 - v2;
			dm = d >= 0 ? d : -d;
			vm = v1 >= 0 ? v1 : -v1;
			qa = dm / vm;
			qr = dm % vm;
			if (qa > QUOT_CAP / 3125) q = QUOT_CAP;
			else q = qa * 3125 + (qr * 3125) / vm;
			if (q > QUOT_CAP) q = QUOT_CAP;
			p = ((d < 0) != (v1 < 0)) ? -longint'(q) : longint'(q);
			sv = sra(p9 * sra(p, 13) * sra(p, 13), 25);
			v2 = sra(p8 * p, 19);
			p = sra(p + sv + v2, 8) + p7 * 16;
			if (p < 0) p = 0;
			if (p > PRESS_CAP) p = PRESS_CAP;
			pq = p;
			if (m_filt_en && m_filt_log2 >= 1 && m_filt_log2 <= 4)
				pq = (longint'(m_filtered) * ((64'd1 << m_filt_log2) - 1) + pq)
					>> m_filt_log2;
			m_filtered = pq[24:0];
		end
		res.temperature_centi_c = temp[14:0];
		res.pressure_q24_8 = pq[24:0];
		res.pressure_invalid = bad;
		return res;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// driver: offer queued readings, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(compensate(in_item));
				void'(pending_readings.pop_front());
				idle_cycles = gap_len();
			end
			if (in_valid && in_stall) begin
				// hold the payload
			end else if (idle_cycles > 0 || drain_hold || pending_readings.size() == 0) begin
				if (idle_cycles > 0) idle_cycles--;
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				in_item <= pending_readings[0];
			end
		end
	end

	// monitor: check results and drive receiver stalls
	always @(posedge clk or negedge arst_n) begin
		bcf_out_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", out_item);
				end else begin
					exp_r = expected_results.pop_front();
					if (out_item !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected temp %0d press %0d inv %0b,",
								" got temp %0d press %0d inv %0b"},
								exp_r.temperature_centi_c, exp_r.pressure_q24_8,
								exp_r.pressure_invalid, out_item.temperature_centi_c,
								out_item.pressure_q24_8, out_item.pressure_invalid);
					end
				end
			end
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 25) ? 1'b1
					: ($urandom_range(0, 199) == 0);
			end
		end
	end

	// watchdog on accepted handshakes
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| pending_readings.size() == 0 && expected_results.size() == 0)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("barometric_compensation_filter_unit verification failed");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TEMP_CAL:  m_temp_cal = val;
			CFG_PRESS_A:   m_press_a = val;
			CFG_PRESS_B:   m_press_b = val;
			CFG_PRESS_C:   m_press_c = val;
			CFG_FILT_EN:   m_filt_en = val[0];
			CFG_FILT_LOG2: m_filt_log2 = val[2:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_readings.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [47:0] cal_words(int t1, int t2, int t3);
		return {16'(t3), 16'(t2), 16'(t1)};
	endfunction

	// realistic calibration with random spread around typical sensor values
	task automatic load_typical();
		write_reg(CFG_TEMP_CAL, cal_words(27504 + $urandom_range(0, 2000) - 1000,
			26435 + $urandom_range(0, 2000) - 1000, -1000));
		write_reg(CFG_PRESS_A, cal_words(36477 + $urandom_range(0, 2000) - 1000,
			-10685, 3024));
		write_reg(CFG_PRESS_B, cal_words(2855, 140, -7));
		write_reg(CFG_PRESS_C, cal_words(15500, -14600, 6000));
	endtask

	function automatic bcf_in_t mk(logic [19:0] p, logic [19:0] t);
		bcf_in_t r;
		r.raw_pressure = p;
		r.raw_temperature = t;
		return r;
	endfunction

	function automatic bcf_in_t typical_reading();
		return mk(20'd415148 + 20'($urandom_range(0, 200000)) - 20'd100000,
			20'd519888 + 20'($urandom_range(0, 200000)) - 20'd100000);
	endfunction

	initial begin
		m_temp_cal = '0; m_press_a = '0; m_press_b = '0; m_press_c = '0;
		m_filt_en = 1'b0; m_filt_log2 = 3'd1; m_filtered = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset calibration: divisor zero, invalid path
		pending_readings.push_back(mk(20'h0, 20'h0));
		pending_readings.push_back(mk(20'hFFFFF, 20'hFFFFF));
		wait_drained();

		// directed extremes with typical calibration
		load_typical();
		write_reg(CFG_FILT_EN, 48'd0);
		pending_readings.push_back(mk(20'h0, 20'h0));
		pending_readings.push_back(mk(20'hFFFFF, 20'hFFFFF));
		pending_readings.push_back(mk(20'hAAAAA, 20'h55555));
		pending_readings.push_back(mk(20'h55555, 20'hAAAAA));
		pending_readings.push_back(mk(20'd415148, 20'd519888));
		wait_drained();

		// extreme calibration words, saturation of temperature and quotient
		write_reg(CFG_TEMP_CAL, 48'hFFFF_FFFF_FFFF);
		write_reg(CFG_PRESS_A, 48'h7FFF_7FFF_0001);
		write_reg(CFG_PRESS_B, 48'h8000_7FFF_8000);
		write_reg(CFG_PRESS_C, 48'h8000_8000_7FFF);
		pending_readings.push_back(mk(20'h0, 20'hFFFFF));
		pending_readings.push_back(mk(20'hFFFFF, 20'h0));
		pending_readings.push_back(mk(20'h12345, 20'h80000));
		wait_drained();
		write_reg(CFG_TEMP_CAL, 48'h7FFF_7FFF_0000);
		write_reg(CFG_TEMP_CAL, 48'h0000_7FFF_0000);
		pending_readings.push_back(mk(20'hFFFFF, 20'hFFFFF));
		pending_readings.push_back(mk(20'h0, 20'h0));
		wait_drained();
		write_reg(CFG_PRESS_A, 48'h0000_0000_FFFF);
		write_reg(CFG_PRESS_A, 48'h8000_8000_FFFF);
		pending_readings.push_back(mk(20'h80000, 20'h7FFFF));
		pending_readings.push_back(mk(20'h0, 20'h0));
		wait_drained();

		// random phases over filter settings, log2 0..7 incl. the off codes
		for (int ph = 0; ph < 16; ph++) begin
			wait_drained();
			if (ph % 4 == 3) begin
				write_reg(CFG_TEMP_CAL, 48'({$urandom, $urandom}));
				write_reg(CFG_PRESS_A, 48'({$urandom, $urandom}));
				write_reg(CFG_PRESS_B, 48'({$urandom, $urandom}));
				write_reg(CFG_PRESS_C, 48'({$urandom, $urandom}));
			end else begin
				load_typical();
			end
			write_reg(CFG_FILT_EN, 48'(ph % 2 == 0 || ph > 12));
			write_reg(CFG_FILT_LOG2, 48'(ph % 8));
			if (ph == 5) rx_hold_cycles = 3000;  // fill the pipe against a held output
			for (int i = 0; i < 90; i++) begin
				if ($urandom_range(0, 9) == 0)
					pending_readings.push_back(mk(20'($urandom), 20'($urandom)));
				else
					pending_readings.push_back(typical_reading());
				if (ph == 9 && i == 40) begin
					// sender pauses until everything has come back
					drain_hold = 1;
					while (expected_results.size() != 0 || in_valid) @(posedge clk);
					drain_hold = 0;
				end
				if (pending_readings.size() > 4) @(posedge clk iff pending_readings.size() <= 4);
			end
		end
		wait_drained();
		if (mismatches == 0)
			$display("barometric_compensation_filter_unit verification clean");
		else
			$display("barometric_compensation_filter_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire
